// ----- hdl/stsq_pkg.sv -----
// ============================================================================
// stsq_pkg
// Shared types and constants of the stimulus select and trigger sequencer.
// ============================================================================
`default_nettype none

package stsq_pkg;

    localparam int DATA_BITS_DEFAULT   = 8;
    localparam int RESET_TICKS_DEFAULT = 1;

    localparam int INDEX_W    = 8;
    localparam int COUNT_W    = 16;
    localparam int PULSES_W   = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS  = 2'd2;

    localparam logic [COUNT_W-1:0]  SETTLE_TICKS_RST = 16'd10;
    localparam logic [PULSES_W-1:0] PULSE_COUNT_RST  = 8'd1;
    localparam logic [COUNT_W-1:0]  PULSE_TICKS_RST  = 16'd5;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_RESET = 3'd1,
        PH_DATA  = 3'd2,
        PH_WAIT  = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    typedef struct packed {
        logic               func;
        logic               enable;
        logic               frame_clock;
        logic               arm_request;
        logic [INDEX_W-1:0] stim_index;
    } tick_t;

    typedef struct packed {
        logic                select_line;
        logic                trigger_line;
        logic                is_armed;
        logic [PULSES_W-1:0] pulses_owed;
    } status_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  settle_ticks;
        logic [PULSES_W-1:0] pulse_count;
        logic [COUNT_W-1:0]  pulse_ticks;
    } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/stsq_cfg_regs.sv -----
// ============================================================================
// stsq_cfg_regs
// Configuration registers: settle time, pulse count and pulse length.
// ============================================================================
`default_nettype none

module stsq_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [stsq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [stsq_pkg::CFG_DATA_W-1:0]  cfg_data,
    output stsq_pkg::cfg_t                        cfg
);

    stsq_pkg::cfg_t cfg_reg;
    stsq_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                stsq_pkg::CFG_SETTLE_TICKS: cfg_next.settle_ticks = cfg_data;
                stsq_pkg::CFG_PULSE_COUNT:
                    cfg_next.pulse_count = cfg_data[stsq_pkg::PULSES_W-1:0];
                stsq_pkg::CFG_PULSE_TICKS:  cfg_next.pulse_ticks = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_ticks <= stsq_pkg::SETTLE_TICKS_RST;
            cfg_reg.pulse_count  <= stsq_pkg::PULSE_COUNT_RST;
            cfg_reg.pulse_ticks  <= stsq_pkg::PULSE_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hdl/stsq_core.sv -----
// ============================================================================
// stsq_core
// Sequencer state: select byte shifter, settle pause, trigger pulse train.
// ============================================================================
`default_nettype none

module stsq_core #(
    parameter int DATA_BITS   = stsq_pkg::DATA_BITS_DEFAULT,
    parameter int RESET_TICKS = stsq_pkg::RESET_TICKS_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire stsq_pkg::tick_t tick,
    input  wire stsq_pkg::cfg_t  cfg,
    output stsq_pkg::status_t    status
);

    localparam int WORD_W = (DATA_BITS > stsq_pkg::INDEX_W) ? DATA_BITS : stsq_pkg::INDEX_W;
    localparam int POS_W  = $clog2(WORD_W);

    stsq_pkg::phase_t                   phase_reg,       phase_next;
    logic [stsq_pkg::COUNT_W-1:0]       phase_tick_reg,  phase_tick_next;
    logic [stsq_pkg::INDEX_W-1:0]       latched_reg,     latched_next;
    logic                               armed_reg,       armed_next;
    logic                               active_reg,      active_next;
    logic [stsq_pkg::PULSES_W-1:0]      pulses_left_reg, pulses_left_next;
    logic [stsq_pkg::COUNT_W-1:0]       remaining_reg,   remaining_next;
    logic                               prev_fc_reg,     prev_fc_next;
    logic                               select_reg,      select_next;
    logic                               trigger_reg,     trigger_next;

    logic [stsq_pkg::COUNT_W-1:0]       tick_inc;
    logic [WORD_W-1:0]                  data_word;
    logic [POS_W-1:0]                   bit_pos;
    logic                               data_bit;
    logic [stsq_pkg::PULSES_W-1:0]      pulses_dec;
    logic                               fired;
    logic                               busy;

    assign tick_inc   = phase_tick_reg + 16'd1;
    assign data_word  = WORD_W'(latched_reg);
    assign bit_pos    = (phase_reg == stsq_pkg::PH_DATA)
                      ? POS_W'(DATA_BITS - 1) - tick_inc[POS_W-1:0]
                      : POS_W'(DATA_BITS - 1);
    assign data_bit   = data_word[bit_pos];
    assign pulses_dec = (pulses_left_reg != '0) ? pulses_left_reg - 8'd1 : '0;
    assign busy       = armed_reg || active_reg || (phase_reg != stsq_pkg::PH_IDLE);

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        phase_tick_next  = phase_tick_reg;
        latched_next     = latched_reg;
        armed_next       = armed_reg;
        active_next      = active_reg;
        pulses_left_next = pulses_left_reg;
        remaining_next   = remaining_reg;
        prev_fc_next     = prev_fc_reg;
        select_next      = select_reg;
        trigger_next     = trigger_reg;
        fired            = 1'b0;

        if (tick.func || (!tick.enable && busy))
        begin
            select_next      = 1'b0;
            trigger_next     = 1'b0;
            armed_next       = 1'b0;
            active_next      = 1'b0;
            pulses_left_next = '0;
            remaining_next   = '0;
            phase_next       = stsq_pkg::PH_IDLE;
            phase_tick_next  = '0;
        end

        if (tick.func)
        begin
            prev_fc_next = tick.frame_clock;
        end
        else if (!tick.enable)
        begin
            prev_fc_next = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                stsq_pkg::PH_RESET:
                begin
                    phase_tick_next = tick_inc;
                    if (tick_inc >= 16'(RESET_TICKS))
                    begin
                        phase_tick_next = '0;
                        select_next     = data_bit;
                        phase_next      = stsq_pkg::PH_DATA;
                    end
                end
                stsq_pkg::PH_DATA:
                begin
                    phase_tick_next = tick_inc;
                    if (tick_inc >= 16'(DATA_BITS))
                    begin
                        select_next     = 1'b0;
                        phase_tick_next = '0;
                        phase_next      = stsq_pkg::PH_WAIT;
                    end
                    else
                    begin
                        select_next = data_bit;
                    end
                end
                stsq_pkg::PH_WAIT:
                begin
                    if (!armed_reg)
                    begin
                        phase_next = stsq_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_tick_next = tick_inc;
                        if (tick_inc >= cfg.settle_ticks)
                        begin
                            pulses_left_next = cfg.pulse_count;
                            phase_next       = stsq_pkg::PH_DONE;
                        end
                    end
                end
                stsq_pkg::PH_DONE:
                begin
                    if (!armed_reg)
                    begin
                        pulses_left_next = '0;
                        phase_next       = stsq_pkg::PH_IDLE;
                    end
                    else if (prev_fc_reg && !tick.frame_clock)
                    begin
                        trigger_next     = 1'b1;
                        remaining_next   = cfg.pulse_ticks;
                        active_next      = 1'b1;
                        fired            = 1'b1;
                        pulses_left_next = pulses_dec;
                        if (pulses_dec == '0)
                        begin
                            armed_next = 1'b0;
                            phase_next = stsq_pkg::PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    phase_next = stsq_pkg::PH_IDLE;
                    if (armed_reg)
                    begin
                        latched_next    = tick.stim_index;
                        phase_tick_next = '0;
                        select_next     = 1'b1;
                        phase_next      = stsq_pkg::PH_RESET;
                    end
                end
            endcase

            prev_fc_next = tick.frame_clock;

            if (active_next)
            begin
                if (!fired && remaining_next != '0)
                begin
                    remaining_next = remaining_next - 16'd1;
                end
                if (remaining_next == '0)
                begin
                    trigger_next = 1'b0;
                    active_next  = 1'b0;
                end
            end

            if (tick.arm_request)
            begin
                armed_next = 1'b1;
            end
        end
    end

    // outputs
    always_comb
    begin
        status.select_line  = select_next;
        status.trigger_line = trigger_next;
        status.is_armed     = armed_next;
        status.pulses_owed  = pulses_left_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= stsq_pkg::PH_IDLE;
            phase_tick_reg  <= '0;
            latched_reg     <= '0;
            armed_reg       <= 1'b0;
            active_reg      <= 1'b0;
            pulses_left_reg <= '0;
            remaining_reg   <= '0;
            prev_fc_reg     <= 1'b0;
            select_reg      <= 1'b0;
            trigger_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            phase_tick_reg  <= phase_tick_next;
            latched_reg     <= latched_next;
            armed_reg       <= armed_next;
            active_reg      <= active_next;
            pulses_left_reg <= pulses_left_next;
            remaining_reg   <= remaining_next;
            prev_fc_reg     <= prev_fc_next;
            select_reg      <= select_next;
            trigger_reg     <= trigger_next;
        end
    end

    a_trigger_tracks_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        trigger_reg == active_reg)
        else $error("trigger level out of step with pulse timer");

    a_select_only_sending: assert property (@(posedge clk) disable iff (!rst_n)
        select_reg |-> (phase_reg == stsq_pkg::PH_RESET || phase_reg == stsq_pkg::PH_DATA))
        else $error("select line high outside transmission");

    a_pulses_only_in_train: assert property (@(posedge clk) disable iff (!rst_n)
        (pulses_left_reg != '0) |-> (phase_reg == stsq_pkg::PH_DONE))
        else $error("pulses owed outside a train");

    a_abort_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && tick.func) |=> (phase_reg == stsq_pkg::PH_IDLE && !armed_reg && !trigger_reg))
        else $error("abort did not clear the sequencer");

endmodule

`default_nettype wire

// ----- hdl/stim_select_and_trigger_sequencer.sv -----
// ============================================================================
// stim_select_and_trigger_sequencer
// Serial stimulus select and frame-locked trigger pulse train.
// ============================================================================
// Requests arrive on tick (tick_valid / tick_stall), one per tick or abort.
// Every request yields exactly one status request on status (status_valid /
// status_stall) carrying the select and trigger levels, armed flag and the
// pulses still owed after that tick.
// An accepted request is registered in the input register, then processed
// against the sequencer state as it moves into the status register, from
// which its status is valid.
// Throughput: one request per cycle; the state update is a single pass of
// counter compares between the input register and the status register.
// When status_stall holds, the status register keeps its request, the input
// register fills, and tick_stall rises once both are occupied.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next
// edge; indexes beyond the register list are ignored.
// Reset clears both stages, the sequencer state and restores the register
// defaults (settle 10, one pulse, pulse length 5).
// ============================================================================
`default_nettype none

module stim_select_and_trigger_sequencer #(
    parameter int DATA_BITS   = stsq_pkg::DATA_BITS_DEFAULT,
    parameter int RESET_TICKS = stsq_pkg::RESET_TICKS_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             tick_valid,
    output logic                                  tick_stall,
    input  wire stsq_pkg::tick_t                  tick,
    output logic                                  status_valid,
    input  wire logic                             status_stall,
    output stsq_pkg::status_t                     status,
    input  wire logic                             cfg_we,
    input  wire logic [stsq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [stsq_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic               tick_vld_reg,   tick_vld_next;
    stsq_pkg::tick_t    tick_reg;
    logic               status_vld_reg, status_vld_next;
    stsq_pkg::status_t  status_reg;
    stsq_pkg::status_t  status_calc;
    stsq_pkg::cfg_t     cfg;
    logic               accept;
    logic               advance;

    assign advance    = tick_vld_reg && (!status_vld_reg || !status_stall);
    assign tick_stall = tick_vld_reg && !advance;
    assign accept     = tick_valid && !tick_stall;

    always_comb
    begin
        tick_vld_next = tick_vld_reg;
        if (accept)
        begin
            tick_vld_next = 1'b1;
        end
        else if (advance)
        begin
            tick_vld_next = 1'b0;
        end

        status_vld_next = status_vld_reg;
        if (advance)
        begin
            status_vld_next = 1'b1;
        end
        else if (!status_stall)
        begin
            status_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_vld_reg   <= 1'b0;
            status_vld_reg <= 1'b0;
        end
        else
        begin
            tick_vld_reg   <= tick_vld_next;
            status_vld_reg <= status_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tick_reg <= tick;
        end
        if (advance)
        begin
            status_reg <= status_calc;
        end
    end

    stsq_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    stsq_core #(
        .DATA_BITS   (DATA_BITS),
        .RESET_TICKS (RESET_TICKS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .tick   (tick_reg),
        .cfg    (cfg),
        .status (status_calc)
    );

    assign status_valid = status_vld_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire
